>>> design/spq_pkg.sv
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Operation codes on the request mode field
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] data;
    logic signed [31:0] prio;
  } entry_t;

endpackage

>>> design/spq_req_if.sv
// Request channel of the stable priority queue.
`timescale 1ns / 1ps

interface spq_req_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] data_in;
  logic signed [31:0] priority_in;

  modport source (output valid, output mode, output data_in, output priority_in,
                  input ready);
  modport sink (input valid, input mode, input data_in, input priority_in,
                output ready);
endinterface

>>> design/spq_rsp_if.sv
// Response channel of the stable priority queue.
`timescale 1ns / 1ps

interface spq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data_out;
  logic [4:0]         occupancy;

  modport source (output valid, output status, output data_out, output occupancy,
                  input ready);
  modport sink (input valid, input status, input data_out, input occupancy,
                output ready);
endinterface

>>> design/spq_cell.sv
// One slot of the sorted register chain.
`timescale 1ns / 1ps

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             enq,
  input  logic             deq,
  input  entry_t           new_entry,
  input  logic [CNT_W-1:0] count,
  input  entry_t           prev_q,
  input  logic             prev_behind,
  input  entry_t           next_q,
  output entry_t           q,
  output logic             behind
);

  logic held;

  // Slot is behind the new entry when empty or strictly larger in priority
  assign held   = CNT_W'(IDX) < count;
  assign behind = !held || (q.prio > new_entry.prio);

  // Shift toward the tail on insert, toward the head on removal
  always_ff @(posedge clk) begin
    if (enq && behind) begin
      q <= prev_behind ? prev_q : new_entry;
    end else if (deq) begin
      q <= next_q;
    end
  end

endmodule

>>> design/stable_priority_queue.sv
// A response is registered in the cycle after its request is accepted.
// One request per cycle while the response is not stalled; every slot decides in
// parallel, so the chain of slot registers updates together for enqueue or dequeue.
// A request is taken while the previous response waits, when the response is consumed.
// Reset clears the entry count and the response valid; slot contents stay
// undefined until written and are never read beyond the count.
`timescale 1ns / 1ps

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic   clk,
  input logic   rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic             full;
  logic             empty;
  logic             enq;
  logic             deq;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [31:0]      count_ext;
  entry_t           new_entry;
  entry_t           cell_q [DEPTH];
  logic             behind [DEPTH];
  status_t          status_next;
  logic             rsp_valid;
  status_t          rsp_status;
  logic signed [31:0] rsp_data;
  logic [4:0]       rsp_occ;

  // Take a request unless a response is stalled
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign enq   = accept && (req.mode == MODE_ENQ) && !full;
  assign deq   = accept && (req.mode == MODE_DEQ) && !empty;

  assign new_entry.data = req.data_in;
  assign new_entry.prio = req.priority_in;

  // Build the slot chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_q;
    logic   prev_behind;
    entry_t next_q;

    if (i == 0) begin : g_head
      assign prev_q      = new_entry;
      assign prev_behind = 1'b0;
    end else begin : g_body
      assign prev_q      = cell_q[i-1];
      assign prev_behind = behind[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_q = cell_q[i];
    end else begin : g_link
      assign next_q = cell_q[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .enq         (enq),
      .deq         (deq),
      .new_entry   (new_entry),
      .count       (count),
      .prev_q      (prev_q),
      .prev_behind (prev_behind),
      .next_q      (next_q),
      .q           (cell_q[i]),
      .behind      (behind[i])
    );
  end

  // Next count and status
  always_comb begin
    count_next  = count;
    status_next = ST_ENQ;
    if (req.mode == MODE_ENQ) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next  = count + CNT_W'(1);
        status_next = ST_ENQ;
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next  = count - CNT_W'(1);
        status_next = ST_DEQ;
      end
    end
  end

  assign count_ext = 32'(count_next);

  // Hold count and the response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp_status <= status_next;
      rsp_data   <= deq ? cell_q[0].data : '0;
      rsp_occ    <= count_ext[4:0];
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.data_out  = rsp_data;
  assign rsp.occupancy = rsp_occ;

  // Count stays within the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  // Accepted enqueue into a non-full queue grows the count by one
  a_enq_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_ENQ && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("enqueue did not grow count");

  // Every accepted request yields a pending response next cycle
  a_rsp_follow: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("response missing after request");

  // Dequeue status only when entries were held
  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && req.mode == MODE_DEQ && empty) |=> rsp_status == ST_EMPTY)
    else $error("dequeue from empty queue not flagged");

endmodule
